FILE: hw/rtl/mcbsg_pkg.sv
// ----------------------------------------------------------------------------
// mcbsg_pkg
// Shared types and constants for the bouncing step generator.
// ----------------------------------------------------------------------------
package mcbsg_pkg;

    // default sizing
    localparam int CHANNELS_DEF    = 8;
    localparam int PERIOD_BITS_DEF = 16;

    // field widths
    localparam int OP_W     = 2;
    localparam int CHAN_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int POS_W    = 8;
    localparam int PIN_W    = 8;

    // stream data widths, padded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // apb
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [POS_W-1:0] LIMIT_RESET = 8'd158;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_STOP = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic             halted;
        logic [PIN_W-1:0] direction_pins;
        logic [PIN_W-1:0] step_pins;
    } result_t;

endpackage

FILE: hw/rtl/multi_channel_bouncing_step_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_bouncing_step_generator
// Multi-channel stepper tone generator: each channel steps its head back and
// forth between zero and the track limit at a programmable tick period.
// ----------------------------------------------------------------------------
// latency: a result beat is registered in the result queue when its input beat is accepted
// throughput: one beat per cycle while the result queue is not full; all channels update in parallel in the
//   single combinational pass between the channel state and the result queue
// a two-entry result queue lets input beats keep flowing while a result waits
// reset: aresetn low clears all channel state, the halt flag and the result
//   queue, and sets track_limit to 158; no clearing pass is needed
// ----------------------------------------------------------------------------
module multi_channel_bouncing_step_generator #(
    parameter int CHANNELS    = mcbsg_pkg::CHANNELS_DEF,
    parameter int PERIOD_BITS = mcbsg_pkg::PERIOD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operation[1:0], channel[4:2], period_value[20:5], zero pad[23:21]
    input  logic [mcbsg_pkg::S_DATA_W-1:0]  s_tdata,

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // step_pins[7:0], direction_pins[15:8], halted[16], zero pad[23:17]
    output logic [mcbsg_pkg::M_DATA_W-1:0]  m_tdata,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcbsg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mcbsg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mcbsg_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mcbsg_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = CHAN_W + 2;  // holds channel numbers up to 31

    // ---------------------------------------------------------------- config
    logic [POS_W-1:0] track_limit_reg;
    logic             cfg_write;
    logic             cfg_hit;

    assign pready    = 1'b1;
    // single register at byte address 0, address bit 2 selects beyond it
    assign cfg_hit   = (paddr[2] == 1'b0);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_limit_reg <= LIMIT_RESET;
        end else if (cfg_write && cfg_hit) begin
            track_limit_reg <= pwdata[POS_W-1:0];
        end
    end

    assign prdata = cfg_hit ? {{(APB_DATA_W-POS_W){1'b0}}, track_limit_reg}
                            : '0;

    // ----------------------------------------------------------- input beat
    op_t                 in_op;
    logic [CHAN_W-1:0]   in_chan;
    logic [PERIOD_W-1:0] in_period;
    logic [PERIOD_BITS-1:0] in_period_fit;
    logic                s_accept;

    assign in_op     = op_t'(s_tdata[OP_W-1:0]);
    assign in_chan   = s_tdata[OP_W +: CHAN_W];
    assign in_period = s_tdata[OP_W+CHAN_W +: PERIOD_W];
    assign s_accept  = s_tvalid && s_tready;

    // keep only the low PERIOD_BITS bits, zero extend when wider
    always_comb begin
        for (int b = 0; b < PERIOD_BITS; b++) begin
            in_period_fit[b] = (b < PERIOD_W) ? in_period[b % PERIOD_W] : 1'b0;
        end
    end

    // --------------------------------------------------------- channel state
    logic [PERIOD_BITS-1:0] period_reg   [CHANNELS];
    logic [PERIOD_BITS-1:0] period_next  [CHANNELS];
    logic [PERIOD_BITS-1:0] count_reg    [CHANNELS];
    logic [PERIOD_BITS-1:0] count_next   [CHANNELS];
    logic [POS_W-1:0]       pos_reg      [CHANNELS];
    logic [POS_W-1:0]       pos_next     [CHANNELS];
    logic [CHANNELS-1:0]    reverse_reg;
    logic [CHANNELS-1:0]    reverse_next;
    logic [CHANNELS-1:0]    step_reg;
    logic [CHANNELS-1:0]    step_next;
    logic                   stopped_reg;
    logic                   stopped_next;

    logic                   set_hit;
    logic [CH_IDX_W-1:0]    set_idx;

    // a set to a channel beyond the array is dropped
    assign set_hit = ({{(CMP_W-CHAN_W){1'b0}}, in_chan} < CMP_W'(CHANNELS));
    assign set_idx = CH_IDX_W'(in_chan);

    always_comb begin
        logic [PERIOD_BITS-1:0] cnt_inc;
        logic                   dir;
        cnt_inc      = '0;
        dir          = 1'b0;
        period_next  = period_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        reverse_next = reverse_reg;
        step_next    = step_reg;
        stopped_next = stopped_reg;

        if (!stopped_reg) begin
            unique case (in_op)
                OP_TICK: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        cnt_inc = count_reg[c] + 1'b1;
                        dir     = reverse_reg[c];
                        // silent channel holds everything
                        if (period_reg[c] != '0) begin
                            if (cnt_inc < period_reg[c]) begin
                                count_next[c] = cnt_inc;
                            end else begin
                                count_next[c] = '0;
                                // turn at the limit or at zero
                                if (pos_reg[c] >= track_limit_reg) begin
                                    dir = 1'b1;
                                end else if (pos_reg[c] == '0) begin
                                    dir = 1'b0;
                                end
                                reverse_next[c] = dir;
                                pos_next[c]     = dir ? pos_reg[c] - 1'b1
                                                      : pos_reg[c] + 1'b1;
                                step_next[c]    = ~step_reg[c];
                            end
                        end
                    end
                end
                OP_SET: begin
                    if (set_hit) begin
                        period_next[set_idx] = in_period_fit;
                    end
                end
                OP_STOP: begin
                    // park: all heads reverse, step pins low, halt for good
                    reverse_next = '1;
                    step_next    = '0;
                    stopped_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                period_reg[c] <= '0;
                count_reg[c]  <= '0;
                pos_reg[c]    <= '0;
            end
            reverse_reg <= '0;
            step_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (s_accept) begin
            period_reg  <= period_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            reverse_reg <= reverse_next;
            step_reg    <= step_next;
            stopped_reg <= stopped_next;
        end
    end

    // ------------------------------------------------------------ result beat
    result_t new_res;

    // only the first eight channels reach the pins
    always_comb begin
        new_res.step_pins      = '0;
        new_res.direction_pins = '0;
        for (int c = 0; c < PIN_W; c++) begin
            if (c < CHANNELS) begin
                new_res.step_pins[c]      = step_next[c % CHANNELS];
                new_res.direction_pins[c] = reverse_next[c % CHANNELS];
            end
        end
        new_res.halted = stopped_next;
    end

    // two-entry result queue: head drives the port, tail catches a stalled beat
    result_t    head_reg;
    result_t    tail_reg;
    logic [1:0] fill_reg;
    logic       m_pop;

    assign m_pop    = m_tvalid && m_tready;
    assign m_tvalid = (fill_reg != 2'd0);
    assign s_tready = (fill_reg != 2'd2);
    assign m_tdata  = {{(M_DATA_W-$bits(result_t)){1'b0}}, head_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            unique case (fill_reg)
                2'd0: begin
                    if (s_accept) begin
                        fill_reg <= 2'd1;
                    end
                end
                2'd1: begin
                    if (s_accept && !m_pop) begin
                        fill_reg <= 2'd2;
                    end else if (!s_accept && m_pop) begin
                        fill_reg <= 2'd0;
                    end
                end
                2'd2: begin
                    if (m_pop) begin
                        fill_reg <= 2'd1;
                    end
                end
                default: begin
                    fill_reg <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_reg == 2'd2) begin
            if (m_pop) begin
                head_reg <= tail_reg;
            end
        end else if (s_accept) begin
            if (fill_reg == 2'd0 || m_pop) begin
                head_reg <= new_res;
            end else begin
                tail_reg <= new_res;
            end
        end
    end

endmodule
